>>> hdl/nary_reflected_gray_encoder_defines.svh
// Assertion macros shared by the gray encoder RTL.
// No dependencies; included by the files that assert.
`ifndef NARY_REFLECTED_GRAY_ENCODER_DEFINES_SVH
`define NARY_REFLECTED_GRAY_ENCODER_DEFINES_SVH

// Checked on clk_i, ignored while rst_ni is low.
`define NRGE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Checked on clk_i at every edge, reset included.
`define NRGE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) \
    else $error(msg);

`endif

>>> hdl/nrge_pkg.sv
// Package for the reflected n-ary gray encoder: field widths, register
// indexes, reset values and parameter defaults. No dependencies.
`timescale 1ns / 1ps

package nrge_pkg;

  localparam int unsigned INDEX_W         = 32;
  localparam int unsigned RADIX_W         = 5;
  localparam int unsigned COUNT_W         = 6;
  localparam int unsigned CFG_IDX_W       = 2;
  localparam int unsigned CFG_DATA_W      = 6;

  localparam logic [CFG_IDX_W-1:0] REG_RADIX       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIGIT_COUNT = 2'd1;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd2;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 6'd8;

  localparam int unsigned MAX_DIGITS_DEF  = 32;
  localparam int unsigned DIGIT_WIDTH_DEF = 4;

  // Divider retires this many index bits per cycle.
  localparam int unsigned SLICE_W = 8;
  localparam int unsigned SLICES  = INDEX_W / SLICE_W;

endpackage

>>> hdl/nary_reflected_gray_encoder.sv
// Reflected n-ary gray encoder top level: shared slice divider, digit RAM
// and emit sequencer. Depends on nrge_pkg, nrge_ram and the defines header.
//
//   channel | signals                                   | role
//   --------+-------------------------------------------+---------------
//   cfg     | cfg_valid_i cfg_ready_o cfg_index_i/data  | register write
//   in      | in_valid_i in_ready_o index_i             | index in
//   out     | out_valid_o out_ready_i gray_digit_o ...  | one digit each
//
// A transaction runs the shared divider, retiring 8 index bits per cycle, to
// produce the lower digits one at a time into the RAM, then issues one RAM
// read per emitted digit.
// Reset: radix 2, 8 digits, block idle. A stalled output holds the emit
// sequencer; a new index is taken once the previous word is fully issued.
`timescale 1ns / 1ps
`include "nary_reflected_gray_encoder_defines.svh"

module nary_reflected_gray_encoder import nrge_pkg::*; #(
  parameter int unsigned MAX_DIGITS  = MAX_DIGITS_DEF,
  parameter int unsigned DIGIT_WIDTH = DIGIT_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [INDEX_W-1:0]     index_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [DIGIT_WIDTH-1:0] gray_digit_o,
  output logic                   last_digit_o,
  output logic                   overflow_o
);

  localparam int unsigned DW  = DIGIT_WIDTH;
  localparam int unsigned NW  = DW + 1;
  localparam int unsigned RW  = NW + 1;
  localparam int unsigned CW  = (NW > RADIX_W) ? NW : RADIX_W;
  localparam int unsigned KW  = $clog2(MAX_DIGITS + 1);
  localparam int unsigned KCW = (KW > COUNT_W) ? KW : COUNT_W;
  localparam int unsigned AW  = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int unsigned SW  = (SLICES > 1) ? $clog2(SLICES) : 1;

  typedef enum logic [2:0] {ST_IDLE, ST_DIV, ST_TOP, ST_RD, ST_LD} state_e;

  state_e               st_q;
  logic [RADIX_W-1:0]   radix_q;
  logic [COUNT_W-1:0]   count_q;
  logic                 out_valid_q;
  logic [SW-1:0]        s_q;
  logic [AW-1:0]        j_q;
  logic [AW-1:0]        e_q;
  logic                 flip_q;
  logic                 prev_odd_q;

  logic [NW-1:0]        n_q;
  logic [KW-1:0]        k_q;
  logic [INDEX_W-1:0]   v_q, v_d;
  logic [NW-1:0]        rem_q, rem_d;
  logic                 ovf_q;
  logic [DW-1:0]        gray_q;
  logic                 last_q;
  logic                 ovf_out_q;

  logic [CW-1:0]        r_ext, r_top, r_clamp;
  logic [KCW-1:0]       c_ext, c_clamp;
  logic [NW-1:0]        n_eff;
  logic [KW-1:0]        k_eff;
  logic [NW-1:0]        nm1;
  logic                 top_ovf;
  logic                 last_slice;
  logic                 is_last;
  logic                 out_free;
  logic                 load;
  logic                 reflect;
  logic [DW-1:0]        dj;
  logic [DW-1:0]        g;
  logic [SLICE_W-1:0]   qbits;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [DW-1:0]        ram_wdata;
  logic                 ram_re;
  logic [AW-1:0]        ram_raddr;

  // effective radix and digit count
  always_comb begin
    r_ext = CW'(radix_q);
    r_top = CW'(1) << DW;
    if (r_ext < CW'(2)) begin
      r_clamp = CW'(2);
    end else if (r_ext > r_top) begin
      r_clamp = r_top;
    end else begin
      r_clamp = r_ext;
    end
    n_eff = NW'(r_clamp);
    c_ext = KCW'(count_q);
    if (c_ext == KCW'(0)) begin
      c_clamp = KCW'(1);
    end else if (c_ext > KCW'(MAX_DIGITS)) begin
      c_clamp = KCW'(MAX_DIGITS);
    end else begin
      c_clamp = c_ext;
    end
    k_eff = KW'(c_clamp);
  end

  // shared divider: one slice of restoring division per cycle
  always_comb begin
    logic [RW-1:0] acc;
    acc = RW'(rem_q);
    for (int i = SLICE_W - 1; i >= 0; i--) begin
      acc = {acc[RW-2:0], v_q[INDEX_W-SLICE_W+i]};
      if (acc >= RW'(n_q)) begin
        acc      = acc - RW'(n_q);
        qbits[i] = 1'b1;
      end else begin
        qbits[i] = 1'b0;
      end
    end
    rem_d = acc[NW-1:0];
    v_d   = {v_q[INDEX_W-SLICE_W-1:0], qbits};
  end

  assign nm1        = n_q - NW'(1);
  assign top_ovf    = v_q > INDEX_W'(nm1);
  assign last_slice = (s_q == SW'(SLICES - 1));
  assign is_last    = (e_q == AW'(k_q - KW'(1)));
  assign out_free   = !out_valid_q || out_ready_i;
  assign reflect    = n_q[0] ? flip_q : prev_odd_q;
  assign g          = reflect ? (nm1[DW-1:0] - dj) : dj;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = j_q;
    ram_wdata = rem_d[DW-1:0];
    ram_re    = 1'b0;
    ram_raddr = e_q;
    load      = 1'b0;
    unique case (st_q)
      ST_DIV: begin
        ram_we = last_slice;
      end
      ST_TOP: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = top_ovf ? nm1[DW-1:0] : v_q[DW-1:0];
      end
      ST_RD: begin
        ram_re = 1'b1;
      end
      ST_LD: begin
        if (out_free) begin
          load = 1'b1;
          if (!is_last) begin
            ram_re    = 1'b1;
            ram_raddr = e_q + AW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  nrge_ram #(
    .WIDTH(DW),
    .DEPTH(MAX_DIGITS)
  ) u_digits (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(dj)
  );

  // sequencer, configuration and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      radix_q     <= RADIX_RESET;
      count_q     <= COUNT_RESET;
      out_valid_q <= 1'b0;
      s_q         <= '0;
      j_q         <= '0;
      e_q         <= '0;
      flip_q      <= 1'b0;
      prev_odd_q  <= 1'b0;
      gray_q      <= '0;
      last_q      <= 1'b0;
      ovf_out_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          REG_RADIX:       radix_q <= cfg_data_i[RADIX_W-1:0];
          REG_DIGIT_COUNT: count_q <= cfg_data_i[COUNT_W-1:0];
          default: ;
        endcase
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (st_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            s_q        <= '0;
            j_q        <= AW'(k_eff - KW'(1));
            e_q        <= '0;
            flip_q     <= 1'b0;
            prev_odd_q <= 1'b0;
            st_q       <= (k_eff == KW'(1)) ? ST_TOP : ST_DIV;
          end
        end
        ST_DIV: begin
          if (last_slice) begin
            s_q <= '0;
            j_q <= j_q - AW'(1);
            if (j_q == AW'(1)) begin
              st_q <= ST_TOP;
            end
          end else begin
            s_q <= s_q + SW'(1);
          end
        end
        ST_TOP: begin
          st_q <= ST_RD;
        end
        ST_RD: begin
          st_q <= ST_LD;
        end
        ST_LD: begin
          if (load) begin
            gray_q     <= g;
            last_q     <= is_last;
            ovf_out_q  <= ovf_q;
            flip_q     <= flip_q ^ dj[0];
            prev_odd_q <= dj[0];
            e_q        <= e_q + AW'(1);
            if (is_last) begin
              st_q <= ST_IDLE;
            end
          end
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (st_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          n_q   <= n_eff;
          k_q   <= k_eff;
          v_q   <= index_i;
          rem_q <= '0;
        end
      end
      ST_DIV: begin
        v_q   <= v_d;
        rem_q <= last_slice ? '0 : rem_d;
      end
      ST_TOP: begin
        ovf_q <= top_ovf;
      end
      default: ;
    endcase
  end

  assign cfg_ready_o  = 1'b1;
  assign in_ready_o   = (st_q == ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign gray_digit_o = gray_q;
  assign last_digit_o = last_q;
  assign overflow_o   = ovf_out_q;

  `NRGE_ASSERT(a_busy_after_accept, (in_valid_i && in_ready_o) |=> !in_ready_o,
               "ready after accepting an index")
  `NRGE_ASSERT(a_rem_below_radix, (st_q == ST_DIV) |-> (rem_q < n_q),
               "divider remainder not below radix")
  `NRGE_ASSERT(a_count_in_range,
               (st_q != ST_IDLE) |-> ((k_q >= KW'(1)) && (k_q <= KW'(MAX_DIGITS))),
               "digit count out of range while busy")
  `NRGE_ASSERT(a_ovf_held_in_word,
               (out_valid_q && out_ready_i && !last_q) |=> (ovf_out_q == $past(ovf_out_q)),
               "overflow changed within a word")

endmodule

>>> hdl/nrge_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module nrge_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> verif/nary_reflected_gray_encoder_tb.sv
// Self-checking testbench for nary_reflected_gray_encoder: directed and random
// indexes over many radix/digit-count settings, checked digit by digit.
// Depends on nrge_pkg and the encoder RTL only.
`timescale 1ns / 1ps

module nary_reflected_gray_encoder_tb;
  import nrge_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
  localparam int unsigned LONG_HOLD      = 400;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned TAIL_CYCLES    = 200;

  typedef struct packed {
    logic [DIGIT_WIDTH_DEF-1:0] digit;
    logic                       last;
    logic                       ovf;
  } gray_digit_t;

  class gray_digit_scoreboard;
    logic [RADIX_W-1:0] radix_r = RADIX_RESET;
    logic [COUNT_W-1:0] count_r = COUNT_RESET;
    gray_digit_t        pending_digits[$];
    int                 errors = 0;

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_RADIX:       radix_r = data[RADIX_W-1:0];
        REG_DIGIT_COUNT: count_r = data[COUNT_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned eff_radix();
      int unsigned r;
      r = radix_r;
      if (r < 2) r = 2;
      if (r > (1 << DIGIT_WIDTH_DEF)) r = 1 << DIGIT_WIDTH_DEF;
      return r;
    endfunction

    function int unsigned eff_count();
      int unsigned c;
      c = count_r;
      if (c < 1) c = 1;
      if (c > MAX_DIGITS_DEF) c = MAX_DIGITS_DEF;
      return c;
    endfunction

    function int pending();
      return pending_digits.size();
    endfunction

    // Splits the index into digits and applies the reflection rule.
    function void take_index(logic [INDEX_W-1:0] idx);
      int unsigned       n, k, flips, g;
      int                j;
      longint unsigned   v;
      int unsigned       dg[MAX_DIGITS_DEF];
      bit                ovf, flip;
      gray_digit_t       e;
      n     = eff_radix();
      k     = eff_count();
      v     = idx;
      ovf   = 1'b0;
      flips = 0;
      for (j = k - 1; j >= 1; j--) begin
        dg[j] = v % n;
        v     = v / n;
      end
      if (v > n - 1) begin
        dg[0] = n - 1;
        ovf   = 1'b1;
      end else begin
        dg[0] = v;
      end
      for (j = 0; j < k; j++) begin
        if (n % 2 == 1) begin
          flip = (flips % 2) == 1;
        end else begin
          flip = (j > 0) && (dg[j-1] % 2 == 1);
        end
        g = flip ? n - 1 - dg[j] : dg[j];
        if (dg[j] % 2 == 1) flips++;
        e.digit = g[DIGIT_WIDTH_DEF-1:0];
        e.last  = (j == k - 1);
        e.ovf   = ovf;
        pending_digits.push_back(e);
      end
    endfunction

    function void check_digit(logic [DIGIT_WIDTH_DEF-1:0] digit, logic last, logic ovf);
      gray_digit_t e;
      if (pending_digits.size() == 0) begin
        $display("%0t: unexpected digit %0d last %0b overflow %0b", $time, digit, last, ovf);
        errors++;
        return;
      end
      e = pending_digits.pop_front();
      if (digit !== e.digit) begin
        $display("%0t: gray_digit expected %0d got %0d", $time, e.digit, digit);
        errors++;
      end
      if (last !== e.last) begin
        $display("%0t: last_digit expected %0b got %0b", $time, e.last, last);
        errors++;
      end
      if (ovf !== e.ovf) begin
        $display("%0t: overflow expected %0b got %0b", $time, e.ovf, ovf);
        errors++;
      end
    endfunction
  endclass

  logic                       clk_i       = 1'b0;
  logic                       rst_ni      = 1'b0;
  logic                       cfg_valid_i = 1'b0;
  logic                       cfg_ready_o;
  logic [CFG_IDX_W-1:0]       cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]      cfg_data_i  = '0;
  logic                       in_valid_i  = 1'b0;
  logic                       in_ready_o;
  logic [INDEX_W-1:0]         index_i     = '0;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  logic [DIGIT_WIDTH_DEF-1:0] gray_digit_o;
  logic                       last_digit_o;
  logic                       overflow_o;

  gray_digit_scoreboard sb = new();
  bit          idle_enable  = 1'b1;
  bit          hold_off_req = 1'b0;
  int unsigned stall_cycles = 0;

  nary_reflected_gray_encoder i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .index_i      (index_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .gray_digit_o (gray_digit_o),
    .last_digit_o (last_digit_o),
    .overflow_o   (overflow_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int unsigned gap_len();
    if ($urandom_range(9) == 0) return $urandom_range(20, 60);
    return $urandom_range(1, 4);
  endfunction

  // Mostly indexes that fit the word, some at the boundary, some overflowing.
  function automatic logic [INDEX_W-1:0] pick_index(int unsigned n, int unsigned k);
    longint unsigned lim;
    int unsigned     i;
    lim = 1;
    for (i = 0; i < k && lim <= 64'h1_0000_0000; i++) lim = lim * n;
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: begin
        if (lim > 64'hFFFF_FFFF) return $urandom;
        return $urandom_range(32'(lim - 1));
      end
      6: begin
        if (lim > 64'hFFFF_FFFF) return '1;
        return 32'(lim - 1 + $urandom_range(1));
      end
      7: return $urandom;
      8: return $urandom_range(n * n);
      default: return $urandom_range(1) ? '1 : '0;
    endcase
  endfunction

  task automatic send_index(logic [INDEX_W-1:0] idx);
    in_valid_i <= 1'b1;
    index_i    <= idx;
    do @(posedge clk_i); while (!in_ready_o);
    sb.take_index(idx);
    if (idle_enable && $urandom_range(2) == 0) begin
      in_valid_i <= 1'b0;
      repeat (gap_len()) @(posedge clk_i);
    end
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
  endtask

  task automatic set_code(logic [CFG_DATA_W-1:0] r, logic [CFG_DATA_W-1:0] c, int spares);
    int i;
    write_cfg(REG_RADIX, r);
    write_cfg(REG_DIGIT_COUNT, c);
    for (i = 0; i < spares; i++) write_cfg(i % 2 ? REG_SPARE_B : REG_SPARE_A, 6'($urandom));
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Receiver: random back-pressure, plus one long hold-off on request.
  initial begin
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else if (idle_enable && $urandom_range(3) == 0) begin
        out_ready_i <= 1'b0;
        repeat (gap_len()) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_digit(gray_digit_o, last_digit_o, overflow_o);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int          ph;
    logic [5:0]  r, c;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset setting: radix 2, 8 digits
    send_index(32'd0);
    send_index(32'd255);
    send_index(32'd256);
    send_index(32'hFFFF_FFFF);
    drain();
    set_code(6'd3, 6'd4, 0);
    send_index(32'd80);
    send_index(32'd81);
    send_index(32'd5);
    send_index(32'd0);
    drain();
    set_code(6'd16, 6'd8, 0);
    send_index(32'hFFFF_FFFF);
    send_index(32'h1234_5678);
    drain();
    set_code(6'd16, 6'd1, 0);
    send_index(32'd15);
    send_index(32'd16);
    drain();
    set_code(6'd2, 6'd32, 0);
    send_index(32'hFFFF_FFFF);
    send_index(32'h8000_0001);
    drain();
    // below-range radix and zero digit count
    set_code(6'd0, 6'd0, 0);
    send_index(32'd1);
    send_index(32'd2);
    drain();
    set_code(6'h3F, 6'd63, 0);
    send_index(32'hFEDC_BA98);
    drain();
    // writes to unused register indexes must leave the setting alone
    set_code(6'd17, 6'd33, 2);
    send_index(32'h7FFF_FFFF);
    drain();
    set_code(6'd4, 6'd5, 0);
    send_index(32'd1023);
    send_index(32'd1024);
    send_index(32'h2D3);
    drain();
    set_code(6'd5, 6'd3, 0);
    send_index(32'd124);
    send_index(32'd125);
    send_index(32'd37);

    for (ph = 0; ph < 12; ph++) begin
      drain();
      r = ($urandom_range(4) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(2, 16));
      if ($urandom_range(9) == 0) c = 6'($urandom_range(63));
      else if ($urandom_range(3) == 0) c = 6'($urandom_range(1, 32));
      else c = 6'($urandom_range(1, 10));
      set_code(r, c, ($urandom_range(3) == 0) ? 1 : 0);
      idle_enable = (ph % 4 != 1);
      if (ph == 2) begin
        idle_enable  = 1'b0;
        hold_off_req = 1'b1;
      end
      repeat (11) send_index(pick_index(sb.eff_radix(), sb.eff_count()));
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.pending() != 0) $display("%0t: %0d digits never arrived", $time, sb.pending());
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+hdl
hdl/nrge_pkg.sv
hdl/nrge_ram.sv
hdl/nary_reflected_gray_encoder.sv
verif/nary_reflected_gray_encoder_tb.sv
